// ===== src/bitmap_first_free_allocator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// bitmap first-free allocator assertion macros
// shared concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BFA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define BFA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BFA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define BFA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== src/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// types and constants shared by the bitmap first-free allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfa_pkg;

  // default geometry
  localparam int NUM_ITEMS_DEF = 8192;
  localparam int WORD_BITS_DEF = 64;
  localparam int MAP_WORDS_DEF = (NUM_ITEMS_DEF + WORD_BITS_DEF - 1) / WORD_BITS_DEF;

  // index field width
  localparam int IDX_W = 13;

  // request kinds
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_TEST  = 2'd2;

  // status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_ADR,
    ST_ACC,
    ST_FIN
  } st_t;

  // request payload
  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] index;
  } req_t;

  // response payload
  typedef struct packed {
    logic [IDX_W-1:0] granted_index;
    logic             status;
    logic             was_set;
  } rsp_t;

endpackage

// ===== src/bfa_ram.sv =====
// ----------------------------------------------------------------------------
// bfa_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfa_ram #(
  parameter int WIDTH = bfa_pkg::WORD_BITS_DEF,
  parameter int DEPTH = bfa_pkg::MAP_WORDS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bfa_find_first.sv =====
// ----------------------------------------------------------------------------
// bfa_find_first
// lowest set bit search over one map word by halving the window
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfa_find_first #(
  parameter int WIDTH = bfa_pkg::WORD_BITS_DEF,
  localparam int PW = $clog2(WIDTH),
  localparam int P  = 1 << PW
) (
  input  logic [WIDTH-1:0] vec,
  output logic             found,
  output logic [PW-1:0]    pos
);

  // any candidate at all
  assign found = |vec;

  // binary search, one position bit per step from the top
  always_comb begin
    logic [P-1:0] cur;
    logic [P-1:0] lomask;
    cur = P'(vec);
    pos = '0;
    for (int k = PW - 1; k >= 0; k--) begin
      lomask = (P'(1) << (1 << k)) - P'(1);
      if ((cur & lomask) == '0) begin
        pos[k] = 1'b1;
        cur    = cur >> (1 << k);
      end
    end
  end

endmodule

// ===== src/bitmap_first_free_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_unit
// first-fit bitmap allocator: allocate lowest free, free and test by index
// ----------------------------------------------------------------------------
// usage
//   req channel (valid/ready) carries op and index; rsp channel (valid/ready)
//   returns granted_index, status and was_set, one response per request.
//   allocate scans the map one word per cycle through a single find-first
//   unit and a single-port-read ram, from word 0 up to the word that holds
//   the first free bit, or through the last word when the map is full.
//   free and test go through reciprocal multiply for the word address,
//   remainder, ram read, then update; an unused op code goes to the response.
//   one request is in flight at a time; req_ready is high only while idle.
//   the response sits in an output register, so a new request is taken while
//   the previous response still waits; the block holds in its last step only
//   when the receiver has not yet taken that earlier response.
//   after reset the map ram is swept to all free, one word a cycle, while
//   req_ready stays low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bitmap_first_free_allocator_unit_defines.svh"

module bitmap_first_free_allocator_unit #(
  parameter int NUM_ITEMS = bfa_pkg::NUM_ITEMS_DEF,
  parameter int WORD_BITS = bfa_pkg::WORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bfa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bfa_pkg::rsp_t rsp
);

  localparam int MAP_WORDS = (NUM_ITEMS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int IW        = bfa_pkg::IDX_W;
  localparam int GW        = AW + BW;
  localparam int SH        = IW + BW;
  localparam int RW        = IW + 1;
  localparam int RECIP     = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int NW        = $clog2(NUM_ITEMS + 1);
  localparam int CW        = (NW > IW) ? NW : IW;
  localparam int TAIL      = NUM_ITEMS - (MAP_WORDS - 1) * WORD_BITS;

  localparam logic [AW-1:0]        LAST_WORD = AW'(MAP_WORDS - 1);
  localparam logic [RW-1:0]        RECIP_V   = RW'(RECIP);
  localparam logic [WORD_BITS:0]   TAIL_ONES =
    ((WORD_BITS + 1)'(1) << TAIL) - (WORD_BITS + 1)'(1);
  localparam logic [WORD_BITS-1:0] PAD_MASK  = ~TAIL_ONES[WORD_BITS-1:0];

  bfa_pkg::st_t state;
  bfa_pkg::st_t state_next;

  // request capture and work registers
  logic [1:0]    op_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] div_word;
  logic [BW-1:0] bit_sel;
  logic          in_rng;
  logic [AW-1:0] scan_addr;
  logic [AW-1:0] chk_addr;
  logic          chk_valid;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] fnd_addr;
  logic [BW-1:0] fnd_bit;
  logic          res_grant;
  logic          res_status;
  logic          res_was;

  // ram and datapath wires
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] free_vec;
  logic                 ff_found;
  logic [BW-1:0]        ff_pos;
  logic [BW-1:0]        bit_pos;
  logic [WORD_BITS-1:0] sel_bit;
  logic [IW+RW-1:0]     prod;
  logic [IW-1:0]        quo;
  logic [IW-1:0]        wbase;
  logic [IW-1:0]        rem;
  logic [GW-1:0]        grant_full;
  logic                 load_rsp;

  // allocation map storage
  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // free bits of the word under check, tail bits past the end count as used
  assign free_vec = ~(ram_rdata | ((chk_addr == LAST_WORD) ? PAD_MASK : '0));

  bfa_find_first #(
    .WIDTH (WORD_BITS)
  ) u_ff (
    .vec   (free_vec),
    .found (ff_found),
    .pos   (ff_pos)
  );

  // word address by reciprocal multiply, then remainder
  assign prod  = {{RW{1'b0}}, idx_r} * {{IW{1'b0}}, RECIP_V};
  assign quo   = IW'(prod >> SH);
  assign wbase = IW'(div_word * IW'(WORD_BITS));
  assign rem   = idx_r - wbase;

  // bit mask for set or clear
  assign bit_pos = (state == bfa_pkg::ST_SCAN) ? ff_pos : bit_sel;
  assign sel_bit = WORD_BITS'(1) << bit_pos;

  // item number of the granted bit
  assign grant_full = GW'(fnd_addr) * GW'(WORD_BITS) + GW'(fnd_bit);

  // sequencer next state and ram control
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    load_rsp   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = chk_addr;
    ram_wdata  = ram_rdata | sel_bit;
    ram_raddr  = scan_addr;
    case (state)
      bfa_pkg::ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == LAST_WORD) begin
          state_next = bfa_pkg::ST_IDLE;
        end
      end
      bfa_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          case (req.op) inside
            bfa_pkg::OP_ALLOC:                  state_next = bfa_pkg::ST_SCAN;
            bfa_pkg::OP_FREE, bfa_pkg::OP_TEST: state_next = bfa_pkg::ST_DIV;
            default:                            state_next = bfa_pkg::ST_FIN;
          endcase
        end
      end
      bfa_pkg::ST_SCAN: begin
        if (chk_valid && ff_found) begin
          ram_we     = 1'b1;
          state_next = bfa_pkg::ST_FIN;
        end else if (chk_valid && (chk_addr == LAST_WORD)) begin
          state_next = bfa_pkg::ST_FIN;
        end
      end
      bfa_pkg::ST_DIV: begin
        state_next = bfa_pkg::ST_ADR;
      end
      bfa_pkg::ST_ADR: begin
        ram_raddr  = AW'(div_word);
        state_next = bfa_pkg::ST_ACC;
      end
      bfa_pkg::ST_ACC: begin
        ram_waddr  = AW'(div_word);
        ram_wdata  = ram_rdata & ~sel_bit;
        ram_we     = (op_r == bfa_pkg::OP_FREE) && in_rng;
        state_next = bfa_pkg::ST_FIN;
      end
      bfa_pkg::ST_FIN: begin
        if (!rsp_valid || rsp_ready) begin
          load_rsp   = 1'b1;
          state_next = bfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bfa_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bfa_pkg::ST_CLR;
      clr_addr  <= '0;
      chk_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= load_rsp || (rsp_valid && !rsp_ready);
      if (state == bfa_pkg::ST_CLR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == bfa_pkg::ST_IDLE) begin
        chk_valid <= 1'b0;
      end else if (state == bfa_pkg::ST_SCAN) begin
        chk_valid <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      bfa_pkg::ST_IDLE: begin
        if (req_valid) begin
          op_r       <= req.op;
          idx_r      <= req.index;
          res_grant  <= 1'b0;
          res_status <= bfa_pkg::STATUS_OK;
          res_was    <= 1'b0;
          scan_addr  <= '0;
        end
      end
      bfa_pkg::ST_SCAN: begin
        scan_addr <= (scan_addr == LAST_WORD) ? '0 : scan_addr + AW'(1);
        chk_addr  <= scan_addr;
        if (chk_valid && ff_found) begin
          fnd_addr  <= chk_addr;
          fnd_bit   <= ff_pos;
          res_grant <= 1'b1;
        end else if (chk_valid && (chk_addr == LAST_WORD)) begin
          res_status <= bfa_pkg::STATUS_FULL;
        end
      end
      bfa_pkg::ST_DIV: begin
        div_word <= quo;
      end
      bfa_pkg::ST_ADR: begin
        bit_sel <= rem[BW-1:0];
        in_rng  <= CW'(idx_r) < CW'(NUM_ITEMS);
      end
      bfa_pkg::ST_ACC: begin
        res_was <= in_rng & ram_rdata[bit_sel];
      end
      bfa_pkg::ST_FIN: begin
        if (load_rsp) begin
          rsp.granted_index <= res_grant ? IW'(grant_full) : '0;
          rsp.status        <= res_status;
          rsp.was_set       <= res_was;
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  `BFA_ASSERT_IMP(a_alloc_sets_one, clk, rst, (state == bfa_pkg::ST_SCAN) && ram_we, $onehot(ram_wdata ^ ram_rdata), "allocate write must set exactly one clear bit")
  `BFA_ASSERT_IMP(a_free_only_clears, clk, rst, (state == bfa_pkg::ST_ACC) && ram_we, (ram_wdata & ~ram_rdata) == '0, "free write must not set any bit")
  `BFA_ASSERT_NXT(a_one_in_flight, clk, rst, req_valid && req_ready, !req_ready, "request taken while another is in progress")
  `BFA_ASSERT_IMP(a_full_no_grant, clk, rst, rsp_valid && (rsp.status == bfa_pkg::STATUS_FULL), rsp.granted_index == '0, "full response carries a granted index")

endmodule
